[rtl/core/assert_macros.svh]
// Concurrent assertion macros shared by the RTL files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

[rtl/core/sbks_pkg.sv]
// Package with the codes, widths and cell control type of the sorted key set.
`timescale 1ns / 1ps
`default_nettype none
package sbks_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 256;
  localparam int unsigned CMD_W           = 3;
  localparam int unsigned KEY_W           = 8;
  localparam int unsigned CNT_W           = 9;
  localparam int unsigned POS_W           = 9;
  localparam int unsigned STATUS_W        = 3;
  localparam int unsigned GROUP_SIZE      = 16;

  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEL_KEY = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_POS = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE_KEY,
    OP_DELETE_POS
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/core/sorted_byte_key_set_unit.sv]
// Top level of the sorted byte key set: a chain of key cells with a small sequencer.
//
//  Channel   Direction  Handshake                 Fields
//  command   in         start & !busy             cmd_i, key_i, position_i
//  result    out        done_o (one-cycle strobe) status_o, entry_count_o
//
// Every transaction runs from acceptance to the result strobe through these steps: the
// accepting edge, a search phase in which every cell compares its key and the match
// flags are folded into registered groups of 16, and an apply phase in which the final
// OR decides the status and, for an insert or delete, the whole chain shifts at once.
// A new command may be accepted in the cycle in which the previous result is strobed,
// but not before, as busy holds off the next command until then. After reset the list
// is empty; the key cells are not cleared, as cells at or beyond the count are never
// read. The receiver cannot stall the result, so nothing is ever held back on the output side.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sorted_byte_key_set_unit
  import sbks_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire  logic                clk_i,
  input  wire  logic                rst_ni,
  input  wire  logic                start,
  output logic                      busy,
  input  wire  logic [CMD_W-1:0]    cmd_i,
  input  wire  logic [KEY_W-1:0]    key_i,
  input  wire  logic [POS_W-1:0]    position_i,
  output logic                      done_o,
  output logic [STATUS_W-1:0]       status_o,
  output logic [CNT_W-1:0]          entry_count_o
);

  localparam logic [CNT_W-1:0] MaxCount = CNT_W'(MAX_ENTRIES);

  // Sequencer phases.
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SEARCH = 2'd1;
  localparam logic [1:0] PH_APPLY  = 2'd2;

  logic [1:0]          phase_q, phase_d;
  logic [CMD_W-1:0]    cmd_q;
  logic [KEY_W-1:0]    key_q;
  logic [POS_W-1:0]    pos_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                done_q, done_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                accept;
  logic                found;
  logic                empty;
  logic                pos_bad;
  cell_op_e            op;
  cell_ctrl_t          ctrl;

  logic [KEY_W-1:0]       key_w   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] lt_w;
  logic [MAX_ENTRIES-1:0] match_w;

  assign accept = start && !busy;
  assign busy   = phase_q != PH_IDLE;

  // The command fields are captured once and held until the chain is updated.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      key_q <= key_i;
      pos_q <= position_i;
    end
  end

  // Decision logic of the apply cycle. A match can only come from an occupied
  // cell, so a found key implies a non-empty list.
  assign empty   = count_q == '0;
  assign pos_bad = (pos_q == '0) || ({1'b0, pos_q} > {1'b0, count_q});

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    status_d = status_q;
    done_d   = 1'b0;
    op       = OP_HOLD;
    unique case (phase_q)
      PH_IDLE: begin
        if (accept) phase_d = PH_SEARCH;
      end
      PH_SEARCH: phase_d = PH_APPLY;
      PH_APPLY: begin
        phase_d  = PH_IDLE;
        done_d   = 1'b1;
        status_d = ST_OK;
        unique case (cmd_q)
          CMD_INSERT: begin
            if (found) begin
              status_d = ST_PRESENT;
            end else if (count_q >= MaxCount) begin
              status_d = ST_FULL;
            end else begin
              op      = OP_INSERT;
              count_d = count_q + 1'b1;
            end
          end
          CMD_DEL_KEY: begin
            if (empty) begin
              status_d = ST_EMPTY;
            end else if (!found) begin
              status_d = ST_NOT_FOUND;
            end else begin
              op      = OP_DELETE_KEY;
              count_d = count_q - 1'b1;
            end
          end
          CMD_DEL_POS: begin
            if (pos_bad) begin
              status_d = ST_BAD_POS;
            end else begin
              op      = OP_DELETE_POS;
              count_d = count_q - 1'b1;
            end
          end
          CMD_CHECK: begin
            if (empty) status_d = ST_EMPTY;
            else if (!found) status_d = ST_NOT_FOUND;
          end
          CMD_CLEAR: count_d = '0;
          default: status_d = ST_OK;
        endcase
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  assign ctrl.op  = op;
  assign ctrl.key = key_q;
  assign ctrl.pos = pos_q;

  // The chain. Each cell sees its left neighbor for insertion and its right
  // neighbor for deletion; cell 0 takes the new key from the left.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [KEY_W-1:0] left_key;
    logic             left_lt;
    logic [KEY_W-1:0] right_key;

    if (i == 0) begin : g_first
      assign left_key = key_q;
      assign left_lt  = 1'b0;
    end else begin : g_inner
      assign left_key = key_w[i-1];
      assign left_lt  = lt_w[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_last
      assign right_key = key_w[i];
    end else begin : g_body
      assign right_key = key_w[i+1];
    end

    sbks_cell #(
      .Index(i)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .count_i    (count_q),
      .left_key_i (left_key),
      .left_lt_i  (left_lt),
      .right_key_i(right_key),
      .key_o      (key_w[i]),
      .lt_o       (lt_w[i]),
      .match_o    (match_w[i])
    );
  end

  // Match flags are grouped and registered during the search cycle; the chain
  // does not change then, so the result stays valid for the apply cycle.
  sbks_match_tree #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_match_tree (
    .clk_i  (clk_i),
    .match_i(match_w),
    .any_o  (found)
  );

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q;

  // The count never grows past the capacity.
  `ASSERT_IMPLIES(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= MaxCount)
  // An accepted transaction always enters the search cycle next.
  `ASSERT_NEXT(a_accept_search, clk_i, rst_ni, accept, phase_q == PH_SEARCH)
  // The apply cycle always ends in exactly one result strobe.
  `ASSERT_NEXT(a_apply_done, clk_i, rst_ni, phase_q == PH_APPLY, done_o && !busy)
  // Full is only reported when the list really holds the capacity.
  `ASSERT_IMPLIES(a_full_count, clk_i, rst_ni, done_o && (status_o == ST_FULL),
                  entry_count_o == MaxCount)

endmodule
`default_nettype wire

[rtl/core/sbks_cell.sv]
// One cell of the sorted key chain: holds one key and shifts it on insert or delete.
`timescale 1ns / 1ps
`default_nettype none
module sbks_cell
  import sbks_pkg::*;
#(
  parameter int unsigned Index = 0
) (
  input  wire  logic             clk_i,
  input  wire  cell_ctrl_t       ctrl_i,
  input  wire  logic [CNT_W-1:0] count_i,
  input  wire  logic [KEY_W-1:0] left_key_i,
  input  wire  logic             left_lt_i,
  input  wire  logic [KEY_W-1:0] right_key_i,
  output logic       [KEY_W-1:0] key_o,
  output logic                   lt_o,
  output logic                   match_o
);

  localparam logic [CNT_W-1:0] IdxCnt  = CNT_W'(Index);
  localparam logic [POS_W:0]   IdxNext = (POS_W + 1)'(Index + 1);

  logic [KEY_W-1:0] key_q, key_d;
  logic             occupied;
  logic             before_pos;

  assign occupied   = IdxCnt < count_i;
  assign lt_o       = occupied && (key_q < ctrl_i.key);
  assign match_o    = occupied && (key_q == ctrl_i.key);
  assign before_pos = {1'b0, ctrl_i.pos} > IdxNext;
  assign key_o      = key_q;

  always_comb begin
    key_d = key_q;
    unique case (ctrl_i.op)
      OP_HOLD: key_d = key_q;
      OP_INSERT: begin
        if (!lt_o) key_d = left_lt_i ? ctrl_i.key : left_key_i;
      end
      OP_DELETE_KEY: begin
        if (!lt_o) key_d = right_key_i;
      end
      OP_DELETE_POS: begin
        if (!before_pos) key_d = right_key_i;
      end
      default: key_d = key_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule
`default_nettype wire

[rtl/core/sbks_match_tree.sv]
// Registered first level of the OR reduction over the per-cell match flags.
`timescale 1ns / 1ps
`default_nettype none
module sbks_match_tree
  import sbks_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire  logic                   clk_i,
  input  wire  logic [MAX_ENTRIES-1:0] match_i,
  output logic                         any_o
);

  localparam int unsigned NumGroups = (MAX_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int unsigned PadW      = NumGroups * GROUP_SIZE;

  logic [PadW-1:0]      match_pad;
  logic [NumGroups-1:0] grp_q, grp_d;

  assign match_pad = PadW'(match_i);

  for (genvar g = 0; g < NumGroups; g++) begin : g_group
    assign grp_d[g] = |match_pad[g*GROUP_SIZE +: GROUP_SIZE];
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  assign any_o = |grp_q;

endmodule
`default_nettype wire
